FILE: rtl/bfd_pkg.sv
package bfd_pkg;

   // Fixed field widths.
   localparam int unsigned FREQ_W     = 26;
   localparam int unsigned TARGET_W   = 20;
   localparam int unsigned CONF_W     = 8;
   localparam int unsigned CAP_W      = 16;
   localparam int unsigned ROLL_W     = 16;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 26;

   // Defaults for the top-level parameters.
   localparam int unsigned DEF_TIMER_BITS  = 16;
   localparam int unsigned DEF_QUEUE_DEPTH = 4;

   // Register reset values.
   localparam logic [FREQ_W-1:0]   RST_TICK_RATE     = 26'd5000000;
   localparam logic [TARGET_W-1:0] RST_TARGET_FREQ   = 20'd1427;
   localparam logic [TARGET_W-1:0] RST_TOLERANCE     = 20'd1000;
   localparam logic [CONF_W-1:0]   RST_CONFIRM_COUNT = 8'd6;

   localparam logic [CONF_W-1:0] GOOD_MAX = 8'd255;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_FREQ   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_COUNT = 2'd3;

   typedef struct packed {
      logic [FREQ_W-1:0]   tick_rate;
      logic [TARGET_W-1:0] target_freq;
      logic [TARGET_W-1:0] tolerance;
      logic [CONF_W-1:0]   confirm_count;
   } bfd_cfg_type;

   // One queued work item: an overflow, or a capture with its period.
   typedef struct packed {
      logic                is_capture;
      logic [STAMP_W-1:0]  period;
   } bfd_entry_type;

   typedef struct packed {
      logic                found;
      logic                measured;
      logic [FREQ_W-1:0]   freq_hz;
      logic [CONF_W-1:0]   good_count;
   } bfd_result_type;

endpackage

FILE: rtl/bfd_front.sv
module bfd_front #(
   parameter int unsigned TIMER_BITS = bfd_pkg::DEF_TIMER_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           kind,
   input  logic [bfd_pkg::CAP_W-1:0]      capture_value,
   input  logic                           overflow_pending,
   output bfd_pkg::bfd_entry_type         entry
);
   import bfd_pkg::*;

   localparam int unsigned CapKeep = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
   localparam int unsigned WideW   = TIMER_BITS + ROLL_W;

   logic [ROLL_W-1:0]     rollover_ff, rollover_in;
   logic [STAMP_W-1:0]    last_stamp_ff;
   logic [TIMER_BITS-1:0] cap;
   logic [ROLL_W-1:0]     roll_cap;
   logic [WideW-1:0]      wide;
   logic [STAMP_W-1:0]    stamp;

   always_comb begin
      cap = TIMER_BITS'(capture_value[CapKeep-1:0]);
      // A pending overflow counts only when the capture sits early in the new lap.
      if (overflow_pending && !cap[TIMER_BITS-1]) begin
         roll_cap = rollover_ff + 1'b1;
      end else begin
         roll_cap = rollover_ff;
      end
      wide  = {roll_cap, cap};
      stamp = STAMP_W'(wide);
      if (kind) begin
         rollover_in = roll_cap;
      end else begin
         rollover_in = rollover_ff + 1'b1;
      end
      entry.is_capture = kind;
      entry.period     = stamp - last_stamp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rollover_ff   <= '0;
         last_stamp_ff <= '0;
      end else if (accept) begin
         rollover_ff <= rollover_in;
         if (kind) begin
            last_stamp_ff <= stamp;
         end
      end
   end

endmodule

FILE: rtl/bfd_queue.sv
module bfd_queue #(
   parameter int unsigned DEPTH = bfd_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bfd_pkg::bfd_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output bfd_pkg::bfd_entry_type pop_data,
   output logic                   empty
);
   import bfd_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   bfd_entry_type    slots_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/bfd_back.sv
module bfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bfd_pkg::bfd_cfg_type    cfg,
   input  logic                    q_empty,
   input  bfd_pkg::bfd_entry_type  q_data,
   output logic                    q_pop,
   input  logic                    out_pop,
   output logic                    out_valid,
   output bfd_pkg::bfd_result_type out_data
);
   import bfd_pkg::*;

   localparam int unsigned StepW = $clog2(FREQ_W);
   localparam logic [StepW-1:0] LastStep = StepW'(FREQ_W - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EVAL
   } state_type;

   state_type          state_ff;
   logic [STAMP_W:0]   rem_ff, rem_in;
   logic [FREQ_W-1:0]  quo_ff, quo_in;
   logic [STAMP_W-1:0] div_ff;
   logic [StepW-1:0]   step_ff;
   logic [CONF_W-1:0]  good_ff, good_in;
   logic               latched_ff, latched_in;
   logic               out_valid_ff;
   bfd_result_type     out_ff;

   logic               slot_free;
   logic               out_load;
   logic               simple;
   logic [STAMP_W:0]   shifted;
   logic               fits;
   logic [TARGET_W-1:0] lower;
   logic [TARGET_W:0]   upper;
   logic               in_window;
   logic               latch_kept;
   logic [CONF_W-1:0]  need;
   logic               found;

   assign slot_free = !out_valid_ff || out_pop;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty && slot_free;
   assign simple    = !q_data.is_capture || (q_data.period == '0);
   // A new result enters the output register from either an unmeasured item or a
   // finished window test.
   assign out_load  = (q_pop && simple) || ((state_ff == S_EVAL) && slot_free);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // One restoring division step: bring down the next dividend bit.
   always_comb begin
      shifted = {rem_ff[STAMP_W-1:0], quo_ff[FREQ_W-1]};
      fits    = (shifted >= {1'b0, div_ff});
      rem_in  = fits ? (shifted - {1'b0, div_ff}) : shifted;
      quo_in  = {quo_ff[FREQ_W-2:0], fits};
   end

   // Window test on the finished quotient; both window ends are open.
   always_comb begin
      lower     = (cfg.target_freq > cfg.tolerance) ? (cfg.target_freq - cfg.tolerance) : '0;
      upper     = {1'b0, cfg.target_freq} + {1'b0, cfg.tolerance};
      in_window = (quo_ff > FREQ_W'(lower)) && (quo_ff < FREQ_W'(upper));
      need      = (cfg.confirm_count == '0) ? CONF_W'(1) : cfg.confirm_count;
      if (in_window) begin
         good_in    = (good_ff == GOOD_MAX) ? GOOD_MAX : good_ff + 1'b1;
         latch_kept = latched_ff;
      end else begin
         good_in    = '0;
         latch_kept = 1'b0;
      end
      found      = !latch_kept && (good_in >= need);
      latched_in = latch_kept || found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         good_ff      <= '0;
         latched_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  if (simple) begin
                     out_ff.found        <= 1'b0;
                     out_ff.measured     <= 1'b0;
                     out_ff.freq_hz      <= '0;
                     out_ff.good_count   <= good_ff;
                  end else begin
                     rem_ff   <= '0;
                     quo_ff   <= cfg.tick_rate;
                     div_ff   <= q_data.period;
                     step_ff  <= '0;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == LastStep) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (slot_free) begin
                  good_ff           <= good_in;
                  latched_ff        <= latched_in;
                  out_ff.found      <= found;
                  out_ff.measured   <= 1'b1;
                  out_ff.freq_hz    <= quo_ff;
                  out_ff.good_count <= good_in;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/beacon_frequency_detector_top.sv
// Beacon frequency detector.
//
// The request channel is a queue write port: a transaction is taken at a
// clock edge with req_push high and req_full low. Each transaction is either
// a timer overflow (req_kind low) or a rising-edge capture (req_kind high).
// The response channel is a queue read port: while rsp_empty is low the
// oldest result is on the rsp_ ports, and it is taken with rsp_pop.
// Every request transaction produces exactly one response transaction.
//
// Path: an overflow, or a capture with a zero period, is popped from the
// internal queue straight into the response register. A measured capture
// is popped, then runs the 26-step serial divider and the window test.
// Throughput is one overflow per cycle while the receiver keeps popping; no
// item is popped while a measured capture is still being divided or tested.
//
// Configuration is written through the csr_ channel, which is always ready.
// Reset clears the rollover count, the last stamp, the good run, the latch
// and both queues, and reloads the register defaults. When the receiver
// stalls, the finished result is held and the internal queue absorbs up to
// QUEUE_DEPTH more requests before req_full rises.
module beacon_frequency_detector_top #(
   parameter int unsigned TIMER_BITS  = bfd_pkg::DEF_TIMER_BITS,
   parameter int unsigned QUEUE_DEPTH = bfd_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_kind,
   input  logic [bfd_pkg::CAP_W-1:0]         req_capture_value,
   input  logic                              req_overflow_pending,
   // Response channel.
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_found,
   output logic                              rsp_measured,
   output logic [bfd_pkg::FREQ_W-1:0]        rsp_freq_hz,
   output logic [bfd_pkg::CONF_W-1:0]        rsp_good_count,
   // Configuration channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bfd_pkg::*;

   bfd_cfg_type    cfg_ff;
   bfd_entry_type  front_entry;
   bfd_entry_type  q_data;
   bfd_result_type result;
   logic           q_full, q_empty, q_pop;
   logic           accept;
   logic           out_valid;

   // The register file is always able to take a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_rate     <= RST_TICK_RATE;
         cfg_ff.target_freq   <= RST_TARGET_FREQ;
         cfg_ff.tolerance     <= RST_TOLERANCE;
         cfg_ff.confirm_count <= RST_CONFIRM_COUNT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TICK_RATE:     cfg_ff.tick_rate     <= csr_data[FREQ_W-1:0];
            CSR_TARGET_FREQ:   cfg_ff.target_freq   <= csr_data[TARGET_W-1:0];
            CSR_TOLERANCE:     cfg_ff.tolerance     <= csr_data[TARGET_W-1:0];
            CSR_CONFIRM_COUNT: cfg_ff.confirm_count <= csr_data[CONF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A request is taken whenever the work queue has room.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // Front end: tracks the rollover count and turns captures into periods.
   bfd_front #(
      .TIMER_BITS (TIMER_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .kind             (req_kind),
      .capture_value    (req_capture_value),
      .overflow_pending (req_overflow_pending),
      .entry            (front_entry)
   );

   // Work queue between the front end and the divider.
   bfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // Back end: serial divide, window test and the confirmation run.
   bfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_data  (result)
   );

   assign rsp_empty      = !out_valid;
   assign rsp_found      = result.found;
   assign rsp_measured   = result.measured;
   assign rsp_freq_hz    = result.freq_hz;
   assign rsp_good_count = result.good_count;

endmodule

FILE: rtl/bfd_checker.sv
module bfd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input logic                              rsp_found,
   input logic                              rsp_measured,
   input logic [bfd_pkg::FREQ_W-1:0]        rsp_freq_hz,
   input logic [bfd_pkg::CONF_W-1:0]        rsp_good_count
);
   import bfd_pkg::*;

   // After reset the response side is empty and the request side is not full.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_freq_hz) && $stable(rsp_good_count)
          && $stable(rsp_found) && $stable(rsp_measured)))
      else $error("stalled response changed");

   // A confirmation comes only from a measured period.
   a_found_measured: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_found) |-> (rsp_measured && rsp_good_count != '0))
      else $error("found without a measured good period");

   // An unmeasured item reports no frequency.
   a_unmeasured_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_measured) |-> (rsp_freq_hz == '0 && !rsp_found))
      else $error("unmeasured response carries a frequency");

endmodule

bind beacon_frequency_detector_top bfd_checker u_bfd_checker (.*);

FILE: test/beacon_frequency_detector_top_test.sv
module beacon_frequency_detector_top_test;
   import bfd_pkg::*;

   // Item kinds carried on req_kind.
   localparam logic KIND_OVERFLOW = 1'b0;
   localparam logic KIND_CAPTURE  = 1'b1;

   // Hard stop for the whole run, far above the slowest legal run.
   localparam int unsigned CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic             kind;
      logic [CAP_W-1:0] cap;
      logic             pend;
   } beacon_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_kind = 1'b0;
   logic [CAP_W-1:0]      req_capture_value = '0;
   logic                  req_overflow_pending = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_found;
   logic                  rsp_measured;
   logic [FREQ_W-1:0]     rsp_freq_hz;
   logic [CONF_W-1:0]     rsp_good_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Our own copy of the detector: registers, rollover count, last stamp,
   // consecutive good periods and the found latch.
   bfd_cfg_type           cfg = '{RST_TICK_RATE, RST_TARGET_FREQ, RST_TOLERANCE,
                                  RST_CONFIRM_COUNT};
   logic [ROLL_W-1:0]     roll_cnt = '0;
   logic [STAMP_W-1:0]    prev_stamp = '0;
   logic [CONF_W-1:0]     run_len = '0;
   logic                  locked = 1'b0;

   // Events waiting to be sent, and detector reports waiting to come back.
   beacon_event_type      event_backlog[$];
   bfd_result_type        pending_reports[$];

   // The stimulus generator tracks the timer the same way the detector does,
   // so that it can place captures at a chosen period.
   logic [ROLL_W-1:0]     gen_roll = '0;
   logic [STAMP_W-1:0]    gen_last = '0;
   int unsigned           queued_total = 0;

   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           send_wait = 0;
   int unsigned           send_span = 0;
   bit                    send_steady = 1'b0;
   int unsigned           take_wait = 0;
   int unsigned           take_span = 0;
   bit                    take_steady = 1'b0;

   beacon_frequency_detector_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_kind             (req_kind),
      .req_capture_value    (req_capture_value),
      .req_overflow_pending (req_overflow_pending),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_found            (rsp_found),
      .rsp_measured         (rsp_measured),
      .rsp_freq_hz          (rsp_freq_hz),
      .rsp_good_count       (rsp_good_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the detector copy by one event and return the report it gives.
   // An overflow only bumps the rollover count. A capture forms a 32-bit
   // stamp, and a nonzero period is turned into a frequency and tested
   // against the open window around the target.
   function automatic bfd_result_type predict_detection(input beacon_event_type ev);
      bfd_result_type rep;
      logic [31:0]    stamp;
      logic [31:0]    period;
      logic [31:0]    freq;
      logic [31:0]    lower;
      logic [31:0]    upper;
      logic [31:0]    need;
      rep = '0;
      if (ev.kind == KIND_OVERFLOW) begin
         roll_cnt = roll_cnt + 1'b1;
      end else begin
         // A pending overflow only counts when the capture is in the lower
         // half of the timer range, i.e. the timer has already wrapped.
         if (ev.pend && !ev.cap[CAP_W-1]) begin
            roll_cnt = roll_cnt + 1'b1;
         end
         stamp = {roll_cnt, ev.cap};
         period = stamp - prev_stamp;
         prev_stamp = stamp;
         if (period != 0) begin
            lower = (cfg.target_freq > cfg.tolerance) ?
                    cfg.target_freq - cfg.tolerance : 32'd0;
            upper = cfg.target_freq + cfg.tolerance;
            need = (cfg.confirm_count != 0) ? cfg.confirm_count : 32'd1;
            freq = cfg.tick_rate / period;
            rep.measured = 1'b1;
            rep.freq_hz = freq[FREQ_W-1:0];
            if (freq > lower && freq < upper) begin
               if (run_len != GOOD_MAX) begin
                  run_len = run_len + 1'b1;
               end
            end else begin
               run_len = '0;
               locked = 1'b0;
            end
            if (!locked && run_len >= need) begin
               locked = 1'b1;
               rep.found = 1'b1;
            end
         end
      end
      rep.good_count = run_len;
      return rep;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Driver. The event at the head of the backlog is held on the request
   // ports until the detector takes it, then it is dropped from the backlog.
   // After every transaction a random number of idle cycles is drawn; in
   // steady stretches the next event follows with no idle gap.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            void'(event_backlog.pop_front());
            if (send_span == 0) begin
               send_span = $urandom_range(10, 60);
               send_steady = ($urandom_range(0, 2) == 0);
            end
            send_span--;
            send_wait = send_steady ? 0 : $urandom_range(0, 11);
         end
         if (!req_push || !req_full) begin
            if (send_wait > 0) begin
               send_wait--;
               req_push <= 1'b0;
            end else if (event_backlog.size() > 0) begin
               req_push <= 1'b1;
               req_kind <= event_backlog[0].kind;
               req_capture_value <= event_backlog[0].cap;
               req_overflow_pending <= event_backlog[0].pend;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every request transaction is run through the predictor as it
   // is taken; every response transaction is compared with the oldest
   // prediction. Handling both sides in one block keeps the order of push
   // and pop fixed when both happen together.
   always @(posedge clock) begin
      bfd_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            pending_reports.push_back(predict_detection({req_kind, req_capture_value,
                                                         req_overflow_pending}));
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, actual found=%0d",
                        $time, rsp_found);
               error_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("found", want.found, rsp_found);
               check_field("measured", want.measured, rsp_measured);
               check_field("freq_hz", want.freq_hz, rsp_freq_hz);
               check_field("good_count", want.good_count, rsp_good_count);
            end
            if (take_span == 0) begin
               take_span = $urandom_range(10, 60);
               take_steady = ($urandom_range(0, 2) == 0);
            end
            take_span--;
            take_wait = take_steady ? 0 : $urandom_range(0, 11);
         end
         if (take_wait > 0) begin
            take_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Append one event to the backlog and follow its effect on the timer.
   task automatic queue_event(input logic kind, input logic [CAP_W-1:0] cap,
                              input logic pend);
      beacon_event_type ev;
      ev.kind = kind;
      ev.cap = cap;
      ev.pend = pend;
      event_backlog.push_back(ev);
      queued_total++;
      if (kind == KIND_OVERFLOW) begin
         gen_roll = gen_roll + 1'b1;
      end else begin
         if (pend && !cap[CAP_W-1]) begin
            gen_roll = gen_roll + 1'b1;
         end
         gen_last = {gen_roll, cap};
      end
   endtask

   // Place the next capture a given number of ticks after the last one,
   // sending the timer overflows in between. Now and then the last overflow
   // is left pending and carried by the capture itself. When the gap would
   // need more than eight overflows, a capture at the current rollover
   // count is sent instead, which makes an odd period.
   task automatic queue_capture_after(input logic [31:0] period);
      logic [31:0]       t;
      logic [ROLL_W-1:0] skip;
      logic              carry_pend;
      t = gen_last + period;
      skip = t[31:16] - gen_roll;
      if (skip > 16'd8) begin
         queue_event(KIND_CAPTURE, t[15:0], 1'b0);
      end else begin
         carry_pend = (skip != 0) && !t[15] && ($urandom_range(0, 3) == 0);
         repeat (skip - carry_pend) begin
            queue_event(KIND_OVERFLOW, $urandom, $urandom_range(0, 1));
         end
         // Above the half range a pending flag is ignored, so it is free.
         queue_event(KIND_CAPTURE, t[15:0],
                     carry_pend || (t[15] && ($urandom_range(0, 1) == 1)));
      end
   endtask

   // Mostly periods near the nominal one, so that good runs build up and the
   // beacon gets confirmed, mixed with off-window periods, repeated stamps
   // and random events of either kind.
   task automatic queue_mix(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      logic [31:0] nominal;
      logic [31:0] period;
      goal = queued_total + count;
      while (queued_total < goal) begin
         pick = $urandom_range(0, 99);
         nominal = (cfg.target_freq != 0) ? cfg.tick_rate / cfg.target_freq : 32'd1;
         if (nominal == 0) begin
            nominal = 1;
         end
         if (pick < 72) begin
            if ($urandom_range(0, 2) == 0) begin
               period = nominal;
            end else begin
               period = nominal - nominal / 16 + $urandom_range(0, nominal / 8);
            end
            queue_capture_after(period);
         end else if (pick < 82) begin
            queue_capture_after($urandom_range(1, 150000));
         end else if (pick < 86) begin
            queue_capture_after(32'd0);
         end else begin
            queue_event($urandom_range(0, 1), $urandom, $urandom_range(0, 1));
         end
      end
   endtask

   // Wait until every event is sent and every report has come back.
   task automatic drain();
      while (event_backlog.size() != 0 || req_push || pending_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // One register write; the copy of the register changes once it is taken.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TICK_RATE:     cfg.tick_rate = value[FREQ_W-1:0];
         CSR_TARGET_FREQ:   cfg.target_freq = value[TARGET_W-1:0];
         CSR_TOLERANCE:     cfg.tolerance = value[TARGET_W-1:0];
         CSR_CONFIRM_COUNT: cfg.confirm_count = value[CONF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_window(input logic [FREQ_W-1:0] tick,
                                 input logic [TARGET_W-1:0] target,
                                 input logic [TARGET_W-1:0] tol,
                                 input logic [CONF_W-1:0] confirm);
      @(posedge clock);
      write_reg(CSR_TICK_RATE, tick);
      write_reg(CSR_TARGET_FREQ, target);
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_CONFIRM_COUNT, confirm);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // A random window. The tick rate is chosen from the target so that the
   // nominal period stays short enough to need at most two overflows.
   task automatic program_random();
      logic [TARGET_W-1:0] target;
      logic [TARGET_W-1:0] tol;
      logic [63:0]         tick;
      if ($urandom_range(0, 1) == 0) begin
         target = $urandom_range(1, 2000);
      end else begin
         target = $urandom_range(1, 1000000);
      end
      tick = target * $urandom_range(20, 90000);
      if (tick > 64'd50000000) begin
         tick = 64'd50000000;
      end
      case ($urandom_range(0, 3))
         0:       tol = '0;
         1:       tol = $urandom_range(0, target / 4);
         2:       tol = $urandom_range(0, target);
         default: tol = $urandom_range(target, 1000000);
      endcase
      program_window(tick[FREQ_W-1:0], target, tol, $urandom_range(1, 10));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed events under the reset window (1427 Hz +/- 1000 Hz at
      // 5 MHz ticks, six good periods to confirm). An overflow with junk in
      // its other fields, a capture right after the wrap, a repeated stamp,
      // a pending overflow both below and above the half range, a capture
      // that runs backwards, then seven good periods so the beacon is
      // confirmed and held, one short period that breaks the run, and a
      // capture at the top of the timer.
      queue_event(KIND_OVERFLOW, 16'hFFFF, 1'b1);
      queue_event(KIND_CAPTURE, 16'h0000, 1'b0);
      queue_event(KIND_CAPTURE, 16'h0000, 1'b0);
      queue_event(KIND_CAPTURE, 16'h7FFF, 1'b1);
      queue_event(KIND_CAPTURE, 16'h8000, 1'b1);
      queue_event(KIND_CAPTURE, 16'h1000, 1'b0);
      repeat (7) queue_capture_after(32'd3504);
      queue_capture_after(32'd1);
      queue_event(KIND_CAPTURE, 16'hFFFF, 1'b0);
      queue_mix(180);
      drain();

      // Wide settings: a high tick rate, target and tolerance, so nearly
      // every period lands in the window and the good count saturates.
      program_window(26'd50000000, 20'd1000000, 20'd1000000, 8'd255);
      queue_mix(400);
      drain();

      // Smallest settings: the window (1, 1) is empty.
      program_window(26'd1, 20'd1, 20'd0, 8'd1);
      queue_mix(100);
      drain();

      // A zero tick rate gives a zero frequency, which an open window with
      // a zero lower bound never accepts. Confirm count zero acts as one.
      program_window(26'd0, 20'd4000, 20'd9000, 8'd0);
      queue_mix(60);
      drain();

      // Tolerance above the target with a real tick rate, still with a zero
      // confirm count, so single good periods confirm the beacon.
      program_window(26'd3000000, 20'd600, 20'd900, 8'd0);
      queue_mix(120);
      drain();

      repeat (4) begin
         program_random();
         queue_mix(110);
         drain();
      end

      // Leave room for a stray report after the last expected one.
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bfd_pkg.sv
rtl/bfd_front.sv
rtl/bfd_queue.sv
rtl/bfd_back.sv
rtl/beacon_frequency_detector_top.sv
rtl/bfd_checker.sv
test/beacon_frequency_detector_top_test.sv
